/* hdl/sps_pkg.sv */
// Shared types and constants for the sorted pressed-button set.
package sps_pkg;

   localparam int OUT_W  = 6;   // width of the count fields in a result word
   localparam int CODE_W = 16;  // button code width

   localparam logic KIND_PRESS   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_CHK,
      ST_INS_WR,
      ST_ERS_CHK,
      ST_ERS_WR,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // latch request word, set up walk pointers
      logic rd;         // read list entry at the walk pointer
      logic ins_write;  // shift entry up or drop the code in, per compare
      logic ins_place;  // write the code at slot 0
      logic ers_step;   // keep entry if it differs from the code
      logic ers_end;    // commit compacted count
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;       // list holds CAPACITY entries
      logic ptr_zero;   // insert walk reached slot 0
      logic ptr_end;    // erase walk passed the last entry
      logic data_ge;    // entry read is not below the code
   } status_type;

endpackage

/* hdl/sorted_pressed_button_set.sv */
// Top level of the sorted pressed-button set: controller plus datapath.
//
//  channel   ports                                        handshake
//  --------  -------------------------------------------  -----------------------
//  request   req_kind, req_button, req_from_pointer       start & !busy
//  response  rsp_held_count, rsp_dropped,                 rsp_valid, one cycle,
//            rsp_removed_copies                           cannot be held off
//
//  Per word: an ignored or dropped word goes from accept straight to the result.
//  An insert walks down from the top entry, moving each entry with a memory
//  read, then a write, until the code finds its slot or lands in slot 0.
//  A release walks every stored entry, reading each one and keeping it
//  only if it differs from the code.
//  Reset clears the count and controller; memory contents need no clearing,
//  since only slots below the count are ever read. busy holds off new words.
module sorted_pressed_button_set #(
   parameter int CAPACITY = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_kind,
   input  logic [sps_pkg::CODE_W-1:0] req_button,
   input  logic                       req_from_pointer,
   output logic                       rsp_valid,
   output logic [sps_pkg::OUT_W-1:0]  rsp_held_count,
   output logic                       rsp_dropped,
   output logic [sps_pkg::OUT_W-1:0]  rsp_removed_copies
);
   import sps_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing: idle -> walk -> one-cycle result strobe
   sps_controller u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_from_pointer (req_from_pointer),
      .status           (status),
      .cmd              (cmd),
      .rsp_valid        (rsp_valid)
   );

   // list memory, pointers and result registers
   sps_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_kind),
      .req_button         (req_button),
      .req_from_pointer   (req_from_pointer),
      .rsp_held_count     (rsp_held_count),
      .rsp_dropped        (rsp_dropped),
      .rsp_removed_copies (rsp_removed_copies)
   );

endmodule

/* hdl/sps_datapath.sv */
// Datapath: list memory, walk pointers, count and result registers.
module sps_datapath #(
   parameter int CAPACITY = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sps_pkg::cmd_type          cmd,
   output sps_pkg::status_type       status,
   input  logic                      req_kind,
   input  logic [sps_pkg::CODE_W-1:0] req_button,
   input  logic                      req_from_pointer,
   output logic [sps_pkg::OUT_W-1:0] rsp_held_count,
   output logic                      rsp_dropped,
   output logic [sps_pkg::OUT_W-1:0] rsp_removed_copies
);
   import sps_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [CODE_W-1:0] list_mem [CAPACITY];

   logic [CODE_W-1:0] code_ff,    code_in;
   logic [CODE_W-1:0] rd_data_ff;
   logic              req_kind_ff, req_kind_in;
   logic [CW-1:0]     count_ff,   count_in;
   logic [CW-1:0]     ptr_ff,     ptr_in;
   logic [CW-1:0]     keep_ff,    keep_in;
   logic              dropped_ff, dropped_in;
   logic [CW-1:0]     removed_ff, removed_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [CODE_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [CW-1:0]     ptr_dec;
   logic [CW+OUT_W-1:0] held_wide, removed_wide;

   assign ptr_dec = ptr_ff - CW'(1);
   // insert walks downward reading the slot below the pointer; erase reads at it
   assign rd_addr = (req_kind_ff == KIND_RELEASE) ? ptr_ff[AW-1:0] : ptr_dec[AW-1:0];

   assign status.full     = (count_ff == CW'(CAPACITY));
   assign status.ptr_zero = (ptr_ff == '0);
   assign status.ptr_end  = (ptr_ff == count_ff);
   assign status.data_ge  = (rd_data_ff >= code_ff);

   always_comb begin
      code_in     = code_ff;
      req_kind_in = req_kind_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      keep_in     = keep_ff;
      dropped_in  = dropped_ff;
      removed_in  = removed_ff;
      wr_en       = 1'b0;
      wr_addr     = ptr_ff[AW-1:0];
      wr_data     = code_ff;
      if (cmd.load) begin
         code_in     = req_button;
         req_kind_in = req_kind;
         ptr_in      = (req_kind == KIND_PRESS) ? count_ff : '0;
         keep_in     = '0;
         dropped_in  = req_from_pointer && (req_kind == KIND_PRESS) && status.full;
         removed_in  = '0;
      end
      if (cmd.ins_write) begin
         wr_en = 1'b1;
         if (status.data_ge) begin
            wr_data = rd_data_ff;
            ptr_in  = ptr_dec;
         end else begin
            wr_data  = code_ff;
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.ins_place) begin
         wr_en    = 1'b1;
         wr_data  = code_ff;
         count_in = count_ff + CW'(1);
      end
      if (cmd.ers_step) begin
         ptr_in  = ptr_ff + CW'(1);
         wr_addr = keep_ff[AW-1:0];
         wr_data = rd_data_ff;
         if (rd_data_ff != code_ff) begin
            wr_en   = 1'b1;
            keep_in = keep_ff + CW'(1);
         end
      end
      if (cmd.ers_end) begin
         count_in   = keep_ff;
         removed_in = count_ff - keep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         list_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= list_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      code_ff     <= code_in;
      req_kind_ff <= req_kind_in;
      ptr_ff      <= ptr_in;
      keep_ff     <= keep_in;
      dropped_ff  <= dropped_in;
      removed_ff  <= removed_in;
   end

   // counts are reported modulo 64
   assign held_wide          = (CW + OUT_W)'(count_ff);
   assign removed_wide       = (CW + OUT_W)'(removed_ff);
   assign rsp_held_count     = held_wide[OUT_W-1:0];
   assign rsp_removed_copies = removed_wide[OUT_W-1:0];
   assign rsp_dropped        = dropped_ff;

endmodule

/* hdl/sps_controller.sv */
// Controller: sequences the insert and erase walks over the list memory.
module sps_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_kind,
   input  logic                req_from_pointer,
   input  sps_pkg::status_type status,
   output sps_pkg::cmd_type    cmd,
   output logic                rsp_valid
);
   import sps_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (!req_from_pointer) begin
                  state_in = ST_DONE;
               end else if (req_kind == KIND_RELEASE) begin
                  state_in = ST_ERS_CHK;
               end else if (status.full) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_INS_CHK;
               end
            end
         end
         ST_INS_CHK: state_in = status.ptr_zero ? ST_DONE : ST_INS_WR;
         ST_INS_WR:  state_in = status.data_ge ? ST_INS_CHK : ST_DONE;
         ST_ERS_CHK: state_in = status.ptr_end ? ST_DONE : ST_ERS_WR;
         ST_ERS_WR:  state_in = ST_ERS_CHK;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_INS_CHK: begin
            cmd.ins_place = status.ptr_zero;
            cmd.rd        = !status.ptr_zero;
         end
         ST_INS_WR:  cmd.ins_write = 1'b1;
         ST_ERS_CHK: begin
            cmd.ers_end = status.ptr_end;
            cmd.rd      = !status.ptr_end;
         end
         ST_ERS_WR:  cmd.ers_step = 1'b1;
         ST_DONE:    rsp_valid = 1'b1;
         default:    busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* bench/sps_checker.sv */
// Checker for the sorted pressed-button set: tracks the held list and checks each result word.
`timescale 1ns / 100ps
module sps_checker #(
   parameter int CAPACITY = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       req_kind,
   input  logic [sps_pkg::CODE_W-1:0] req_button,
   input  logic                       req_from_pointer,
   input  logic                       rsp_valid,
   input  logic [sps_pkg::OUT_W-1:0]  rsp_held_count,
   input  logic                       rsp_dropped,
   input  logic [sps_pkg::OUT_W-1:0]  rsp_removed_copies,
   output int                         fail_count,
   output int                         pending,
   output int                         word_total,
   output int                         drop_total,
   output int                         peak_held,
   output int                         peak_removed
);
   import sps_pkg::*;

   typedef struct packed {
      logic [OUT_W-1:0] held_count;
      logic             dropped;
      logic [OUT_W-1:0] removed_copies;
   } status_word_type;

   logic [CODE_W-1:0] held_codes [CAPACITY];
   int                held_total;
   status_word_type   awaited_status [$];

   // Applies one event to the tracked list and returns the status word it should produce.
   function automatic status_word_type track_event(input logic kind,
                                                   input logic [CODE_W-1:0] code,
                                                   input logic pointer_src);
      status_word_type outcome;
      int              pos;
      int              keep;
      int              k;
      outcome = '0;
      if (pointer_src) begin
         if (kind == KIND_PRESS) begin
            if (held_total >= CAPACITY) begin
               outcome.dropped = 1'b1;
            end else begin
               pos = 0;
               while (pos < held_total && held_codes[pos] < code) pos++;
               for (k = held_total; k > pos; k--) held_codes[k] = held_codes[k-1];
               held_codes[pos] = code;
               held_total++;
            end
         end else begin
            keep = 0;
            for (k = 0; k < held_total; k++) begin
               if (held_codes[k] != code) begin
                  held_codes[keep] = held_codes[k];
                  keep++;
               end
            end
            outcome.removed_copies = OUT_W'(held_total - keep);
            for (k = keep; k < held_total; k++) held_codes[k] = '0;
            held_total = keep;
         end
      end
      outcome.held_count = OUT_W'(held_total);
      return outcome;
   endfunction

   initial begin
      fail_count   = 0;
      pending      = 0;
      word_total   = 0;
      drop_total   = 0;
      peak_held    = 0;
      peak_removed = 0;
      held_total   = 0;
      foreach (held_codes[i]) held_codes[i] = '0;
   end

   always @(posedge clock) begin
      status_word_type want;
      if (reset) begin
         held_total = 0;
         foreach (held_codes[i]) held_codes[i] = '0;
         awaited_status.delete();
      end else begin
         if (start && !busy) begin
            awaited_status.push_back(track_event(req_kind, req_button, req_from_pointer));
            word_total++;
         end
         if (rsp_valid) begin
            if (awaited_status.size() == 0) begin
               $error("result word with no word outstanding");
               fail_count++;
            end else begin
               want = awaited_status.pop_front();
               if (rsp_held_count !== want.held_count) begin
                  $error("held_count: expected %0d, actual %0d", want.held_count, rsp_held_count);
                  fail_count++;
               end
               if (rsp_dropped !== want.dropped) begin
                  $error("dropped: expected %0d, actual %0d", want.dropped, rsp_dropped);
                  fail_count++;
               end
               if (rsp_removed_copies !== want.removed_copies) begin
                  $error("removed_copies: expected %0d, actual %0d",
                         want.removed_copies, rsp_removed_copies);
                  fail_count++;
               end
               if (want.dropped) drop_total++;
               if (int'(want.held_count) > peak_held) peak_held = int'(want.held_count);
               if (int'(want.removed_copies) > peak_removed) begin
                  peak_removed = int'(want.removed_copies);
               end
            end
         end
      end
      pending = awaited_status.size();
   end

endmodule

/* bench/tb_sorted_pressed_button_set.sv */
// Bench top for the sorted pressed-button set: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module tb_sorted_pressed_button_set;
   import sps_pkg::*;

   localparam int CAPACITY     = 32;
   localparam int RANDOM_WORDS = 2000;
   // Slowest word is a release over a full list, and the longest sender gaps come
   // at 71% idle. The stall limit is set far past both.
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 100;   // quiet time after the last result

   // Random traffic shapes: filling pushes the list to full so presses drop,
   // stacking piles copies of one code so a release removes many at once.
   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_STACK,
      MODE_SCATTER
   } traffic_mode_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_kind;
   logic [CODE_W-1:0]          req_button;
   logic                       req_from_pointer;
   logic                       rsp_valid;
   logic [OUT_W-1:0]           rsp_held_count;
   logic                       rsp_dropped;
   logic [OUT_W-1:0]           rsp_removed_copies;

   int fail_count;
   int pending;
   int word_total;
   int drop_total;
   int peak_held;
   int peak_removed;
   int idle_pct;
   int quiet_cycles;

   // Small code pool so releases often hit stored codes; extremes included.
   logic [CODE_W-1:0] code_pool [8] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
                                        16'h0001, 16'h00FF, 16'h1234, 16'hFF00};

   sorted_pressed_button_set #(
      .CAPACITY(CAPACITY)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_button        (req_button),
      .req_from_pointer  (req_from_pointer),
      .rsp_valid         (rsp_valid),
      .rsp_held_count    (rsp_held_count),
      .rsp_dropped       (rsp_dropped),
      .rsp_removed_copies(rsp_removed_copies)
   );

   sps_checker #(
      .CAPACITY(CAPACITY)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_button        (req_button),
      .req_from_pointer  (req_from_pointer),
      .rsp_valid         (rsp_valid),
      .rsp_held_count    (rsp_held_count),
      .rsp_dropped       (rsp_dropped),
      .rsp_removed_copies(rsp_removed_copies),
      .fail_count        (fail_count),
      .pending           (pending),
      .word_total        (word_total),
      .drop_total        (drop_total),
      .peak_held         (peak_held),
      .peak_removed      (peak_removed)
   );

   always #6 clock = ~clock;

   // Watchdog: any cycle with neither an accepted word nor a result counts as quiet.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Offers one word. start stays high after acceptance; it only drops when
   // the next call chooses a gap, so start never gets two updates in one step.
   // busy is sampled at the falling edge, where it is stable.
   task automatic send_word(input logic kind, input logic [CODE_W-1:0] code,
                            input logic pointer_src);
      logic was_busy;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start            <= 1'b1;
      req_kind         <= kind;
      req_button       <= code;
      req_from_pointer <= pointer_src;
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
   endtask

   function automatic logic [CODE_W-1:0] pick_code(input int pool_pct);
      if ($urandom_range(99) < pool_pct) return code_pool[$urandom_range(7)];
      return CODE_W'($urandom);
   endfunction

   initial begin
      traffic_mode_type  mode;
      int                mode_left;
      int                sent;
      logic              kind;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] stack_code;

      clock            = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_kind         = KIND_PRESS;
      req_button       = '0;
      req_from_pointer = 1'b0;
      quiet_cycles     = 0;
      idle_pct         = 23;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored events, release on an empty list, extremes,
      // duplicates at head, middle and tail, absent release, multi-copy releases.
      send_word(KIND_RELEASE, 16'h0000, 1'b0);
      send_word(KIND_PRESS,   16'hFFFF, 1'b0);
      send_word(KIND_RELEASE, 16'h1234, 1'b1);
      send_word(KIND_PRESS,   16'hFFFF, 1'b1);
      send_word(KIND_PRESS,   16'h0000, 1'b1);
      send_word(KIND_PRESS,   16'h8000, 1'b1);
      send_word(KIND_PRESS,   16'h7FFF, 1'b1);
      send_word(KIND_PRESS,   16'h8000, 1'b1);
      send_word(KIND_PRESS,   16'h0000, 1'b1);
      send_word(KIND_PRESS,   16'hFFFF, 1'b1);
      send_word(KIND_PRESS,   16'h5555, 1'b1);
      send_word(KIND_PRESS,   16'hAAAA, 1'b1);
      send_word(KIND_PRESS,   16'h0001, 1'b0);
      send_word(KIND_RELEASE, 16'h1234, 1'b1);
      send_word(KIND_RELEASE, 16'h8000, 1'b1);
      send_word(KIND_RELEASE, 16'hFFFF, 1'b1);
      send_word(KIND_RELEASE, 16'h0000, 1'b1);
      send_word(KIND_RELEASE, 16'hAAAA, 1'b0);
      send_word(KIND_PRESS,   16'h0001, 1'b1);

      // Random: traffic in blocks of one shape; ~6% ignored noise on top.
      sent      = 0;
      mode_left = 0;
      mode      = MODE_FILL;
      stack_code = '0;
      while (sent < RANDOM_WORDS) begin
         if (mode_left == 0) begin
            mode       = traffic_mode_type'($urandom_range(3));
            mode_left  = $urandom_range(24, 64);
            stack_code = pick_code(50);
         end
         // sender idles 23%, then 71%, then never
         if (sent < RANDOM_WORDS / 3) idle_pct = 23;
         else if (sent < 2 * RANDOM_WORDS / 3) idle_pct = 71;
         else idle_pct = 0;

         if ($urandom_range(99) < 6) begin
            send_word(1'($urandom_range(1)), CODE_W'($urandom), 1'b0);
         end else begin
            case (mode)
               MODE_FILL: begin
                  kind = ($urandom_range(99) < 88) ? KIND_PRESS : KIND_RELEASE;
                  code = pick_code(50);
               end
               MODE_DRAIN: begin
                  kind = ($urandom_range(99) < 85) ? KIND_RELEASE : KIND_PRESS;
                  code = pick_code(80);
               end
               MODE_STACK: begin
                  kind = ($urandom_range(99) < 90) ? KIND_PRESS : KIND_RELEASE;
                  code = ($urandom_range(99) < 85) ? stack_code : pick_code(50);
               end
               default: begin
                  kind = 1'($urandom_range(1));
                  code = pick_code(20);
               end
            endcase
            send_word(kind, code, 1'b1);
            sent++;
            mode_left--;
         end
      end

      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d words, %0d presses dropped on a full list.",
               word_total, drop_total);
      $display("Peak held count %0d, largest single release took out %0d copies.",
               peak_held, peak_removed);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
